FILE: hdl/lr_pkg.sv
// shared constants and types for the line rasterizer
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS    = 10;
    localparam int WIDTH_BITS    = COORD_BITS + 1;
    localparam int ADDR_BITS     = 2 * COORD_BITS;
    localparam int PROD_BITS     = COORD_BITS + WIDTH_BITS;
    localparam int ERR_BITS      = COORD_BITS + 3;
    localparam int STRAIGHT_BITS = COORD_BITS + 2;
    localparam int STEPS_BITS    = COORD_BITS + 1;
    localparam int GLYPH_BITS    = 8;
    localparam int COLOUR_BITS   = 16;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(80);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
        logic                  done;
    } pix_t;

endpackage

`default_nettype wire

FILE: hdl/lr_if.sv
// valid/ready channel interfaces for line rasterizer items and pixel writes
`timescale 1ns / 1ps
`default_nettype none

interface lr_in_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic [lr_pkg::COORD_BITS-1:0]      x_start;
    logic [lr_pkg::COORD_BITS-1:0]      y_start;
    logic [lr_pkg::COORD_BITS-1:0]      x_end;
    logic [lr_pkg::COORD_BITS-1:0]      y_end;
    logic [lr_pkg::GLYPH_BITS-1:0]      glyph;
    logic [lr_pkg::COLOUR_BITS-1:0]     colour;

    modport source (output valid, op, x_start, y_start, x_end, y_end, glyph, colour,
                    input ready);
    modport sink   (input valid, op, x_start, y_start, x_end, y_end, glyph, colour,
                    output ready);
endinterface

interface lr_out_if;
    logic                               valid;
    logic                               ready;
    logic [lr_pkg::ADDR_BITS-1:0]       pixel_address;
    logic [lr_pkg::COORD_BITS-1:0]      pixel_x;
    logic [lr_pkg::COORD_BITS-1:0]      pixel_y;
    logic [lr_pkg::GLYPH_BITS-1:0]      pixel_glyph;
    logic [lr_pkg::COLOUR_BITS-1:0]     pixel_colour;
    logic                               last_of_item;
    logic                               line_done;

    modport source (output valid, pixel_address, pixel_x, pixel_y, pixel_glyph,
                    pixel_colour, last_of_item, line_done,
                    input ready);
    modport sink   (input valid, pixel_address, pixel_x, pixel_y, pixel_glyph,
                    pixel_colour, last_of_item, line_done,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/line_rasterizer.sv
// line rasterizer top level: line setup, step engine, pixel queue and address stage
`timescale 1ns / 1ps
`default_nettype none

// Turns start and step transactions into framebuffer pixel writes, one write per
// cycle at most while the output is not stalled. A start or a step that moves only the
// major axis writes one pixel; a step that also moves the minor axis writes a corner
// pixel first, and a step with no line active writes nothing. A transaction's pixels pass
// through the two-entry pixel queue and then the single output register. The address
// y*screen_width+x is formed by one multiply-add in the output stage. screen_width resets
// to 80; the user must change it only while no line pixels are in flight (not enforced).
module line_rasterizer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lr_pkg::WIDTH_BITS-1:0]   cfg_wr_data,
    lr_in_if.sink                                in_ch,
    lr_out_if.source                             out_ch
);

    localparam int CB = lr_pkg::COORD_BITS;
    localparam int EB = lr_pkg::ERR_BITS;

    logic [lr_pkg::WIDTH_BITS-1:0]      width_reg;

    logic [CB-1:0]                      cur_x_reg, cur_x_next;
    logic [CB-1:0]                      cur_y_reg, cur_y_next;
    logic [EB-1:0]                      err_reg, err_next;
    logic [EB-1:0]                      diag_reg, diag_next;
    logic [lr_pkg::STRAIGHT_BITS-1:0]   straight_reg, straight_next;
    logic [lr_pkg::STEPS_BITS-1:0]      steps_reg, steps_next;
    logic                               x_neg_reg, x_neg_next;
    logic                               y_neg_reg, y_neg_next;
    logic                               x_major_reg, x_major_next;
    logic [lr_pkg::GLYPH_BITS-1:0]      glyph_reg, glyph_next;
    logic [lr_pkg::COLOUR_BITS-1:0]     colour_reg, colour_next;
    logic                               busy_reg, busy_next;

    // pixel queue
    logic [1:0]                         pend_cnt_reg, pend_cnt_next;
    lr_pkg::pix_t                       slot0_reg, slot0_next;
    lr_pkg::pix_t                       slot1_reg, slot1_next;
    logic [lr_pkg::GLYPH_BITS-1:0]      pend_glyph_reg;
    logic [lr_pkg::COLOUR_BITS-1:0]     pend_colour_reg;

    // output register
    logic                               out_valid_reg;
    logic [lr_pkg::ADDR_BITS-1:0]       out_addr_reg;
    lr_pkg::pix_t                       out_pix_reg;
    logic [lr_pkg::GLYPH_BITS-1:0]      out_glyph_reg;
    logic [lr_pkg::COLOUR_BITS-1:0]     out_colour_reg;

    logic                               out_free;
    logic                               pop;
    logic                               accept;
    logic [1:0]                         push_n;
    lr_pkg::pix_t                       push0;
    lr_pkg::pix_t                       push1;

    // line setup
    logic [CB:0]                        dx_w, dy_w, dx_n, dy_n;
    logic [CB-1:0]                      adx, ady, major, minor;
    logic                               x_major_new;

    // step engine
    logic [CB-1:0]                      x_fwd, y_fwd;
    logic [CB-1:0]                      minor_x, minor_y;
    logic [lr_pkg::STEPS_BITS-1:0]      steps_dec;
    logic                               move_minor;

    logic [lr_pkg::PROD_BITS-1:0]       addr_full;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign pop      = (pend_cnt_reg != 2'd0) && out_free;
    assign in_ch.ready = (pend_cnt_reg == 2'd0) || ((pend_cnt_reg == 2'd1) && pop);
    assign accept   = in_ch.valid && in_ch.ready;

    assign dx_w = {1'b0, in_ch.x_end} - {1'b0, in_ch.x_start};
    assign dy_w = {1'b0, in_ch.y_end} - {1'b0, in_ch.y_start};
    assign dx_n = ~dx_w + (CB+1)'(1);
    assign dy_n = ~dy_w + (CB+1)'(1);
    assign adx  = dx_w[CB] ? dx_n[CB-1:0] : dx_w[CB-1:0];
    assign ady  = dy_w[CB] ? dy_n[CB-1:0] : dy_w[CB-1:0];
    assign x_major_new = adx > ady;
    assign major = x_major_new ? adx : ady;
    assign minor = x_major_new ? ady : adx;

    assign move_minor = !err_reg[EB-1];
    assign minor_x    = (move_minor && !x_major_reg)
                        ? (x_neg_reg ? cur_x_reg - CB'(1) : cur_x_reg + CB'(1)) : cur_x_reg;
    assign minor_y    = (move_minor && x_major_reg)
                        ? (y_neg_reg ? cur_y_reg - CB'(1) : cur_y_reg + CB'(1)) : cur_y_reg;
    assign x_fwd      = x_major_reg
                        ? (x_neg_reg ? minor_x - CB'(1) : minor_x + CB'(1)) : minor_x;
    assign y_fwd      = !x_major_reg
                        ? (y_neg_reg ? minor_y - CB'(1) : minor_y + CB'(1)) : minor_y;
    assign steps_dec  = steps_reg - lr_pkg::STEPS_BITS'(1);

    always_comb
    begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        err_next      = err_reg;
        diag_next     = diag_reg;
        straight_next = straight_reg;
        steps_next    = steps_reg;
        x_neg_next    = x_neg_reg;
        y_neg_next    = y_neg_reg;
        x_major_next  = x_major_reg;
        glyph_next    = glyph_reg;
        colour_next   = colour_reg;
        busy_next     = busy_reg;
        push_n        = 2'd0;
        push0         = '0;
        push1         = '0;
        if (accept)
        begin
            if (in_ch.op == lr_pkg::OP_START)
            begin
                x_neg_next    = dx_w[CB];
                y_neg_next    = dy_w[CB];
                x_major_next  = x_major_new;
                err_next      = {2'b00, minor, 1'b0} - {3'b000, major};
                diag_next     = {2'b00, minor, 1'b0} - {2'b00, major, 1'b0};
                straight_next = {1'b0, minor, 1'b0};
                steps_next    = {1'b0, major};
                cur_x_next    = in_ch.x_start;
                cur_y_next    = in_ch.y_start;
                glyph_next    = in_ch.glyph;
                colour_next   = in_ch.colour;
                busy_next     = (major != '0);
                push_n        = 2'd1;
                push0         = '{x: in_ch.x_start, y: in_ch.y_start, last: 1'b1,
                                  done: (major == '0)};
            end
            else if (busy_reg)
            begin
                if (move_minor)
                begin
                    err_next = err_reg + diag_reg;
                end
                else
                begin
                    err_next = err_reg + {1'b0, straight_reg};
                end
                cur_x_next = x_fwd;
                cur_y_next = y_fwd;
                steps_next = steps_dec;
                busy_next  = (steps_dec != '0);
                if (move_minor)
                begin
                    push_n = 2'd2;
                    push0  = '{x: minor_x, y: minor_y, last: 1'b0, done: 1'b0};
                    push1  = '{x: x_fwd, y: y_fwd, last: 1'b1, done: (steps_dec == '0)};
                end
                else
                begin
                    push_n = 2'd1;
                    push0  = '{x: x_fwd, y: y_fwd, last: 1'b1, done: (steps_dec == '0)};
                end
            end
        end
    end

    always_comb
    begin
        slot0_next    = slot0_reg;
        slot1_next    = slot1_reg;
        pend_cnt_next = pend_cnt_reg - {1'b0, pop};
        if (accept)
        begin
            pend_cnt_next = push_n;
            slot0_next    = push0;
            slot1_next    = push1;
        end
        else if (pop && (pend_cnt_reg == 2'd2))
        begin
            slot0_next = slot1_reg;
        end
    end

    assign addr_full = slot0_reg.y * width_reg + lr_pkg::PROD_BITS'(slot0_reg.x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= lr_pkg::WIDTH_RESET;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            diag_reg      <= '0;
            straight_reg  <= '0;
            steps_reg     <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            x_major_reg   <= 1'b0;
            glyph_reg     <= '0;
            colour_reg    <= '0;
            busy_reg      <= 1'b0;
            pend_cnt_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                width_reg <= cfg_wr_data;
            end
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            err_reg      <= err_next;
            diag_reg     <= diag_next;
            straight_reg <= straight_next;
            steps_reg    <= steps_next;
            x_neg_reg    <= x_neg_next;
            y_neg_reg    <= y_neg_next;
            x_major_reg  <= x_major_next;
            glyph_reg    <= glyph_next;
            colour_reg   <= colour_next;
            busy_reg     <= busy_next;
            pend_cnt_reg <= pend_cnt_next;
            if (out_free)
            begin
                out_valid_reg <= (pend_cnt_reg != 2'd0);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        if (accept)
        begin
            pend_glyph_reg  <= glyph_next;
            pend_colour_reg <= colour_next;
        end
        if (pop)
        begin
            out_addr_reg   <= addr_full[lr_pkg::ADDR_BITS-1:0];
            out_pix_reg    <= slot0_reg;
            out_glyph_reg  <= pend_glyph_reg;
            out_colour_reg <= pend_colour_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pixel_address = out_addr_reg;
    assign out_ch.pixel_x       = out_pix_reg.x;
    assign out_ch.pixel_y       = out_pix_reg.y;
    assign out_ch.pixel_glyph   = out_glyph_reg;
    assign out_ch.pixel_colour  = out_colour_reg;
    assign out_ch.last_of_item  = out_pix_reg.last;
    assign out_ch.line_done     = out_pix_reg.done;

    // queue never holds more than one transaction's pixels
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg != 2'd3)
        else $error("pixel queue overflow");

    // an active line always has steps left
    a_busy_steps: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (steps_reg != '0))
        else $error("busy with no steps left");

    // an accepted step on an active line queues at least one pixel
    a_step_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_ch.op == lr_pkg::OP_STEP) && busy_reg) |=> (pend_cnt_reg != 2'd0))
        else $error("step produced no pixel");

    // a start always queues exactly one pixel
    a_start_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_ch.op == lr_pkg::OP_START)) |=> (pend_cnt_reg == 2'd1))
        else $error("start did not queue one pixel");

    // the line's final pixel closes its transaction
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pix_reg.done) |-> out_pix_reg.last)
        else $error("line done on a non-final write");

endmodule

`default_nettype wire
